[src/b64e_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the alphabet lookup for the base64 stream encoder.
package b64e_pkg;

  localparam int unsigned MaxChars = 4;

  localparam logic [7:0] PadChar    = 8'h3D;  // '='
  localparam logic [7:0] UpperAChar = 8'h41;  // 'A'
  localparam logic [7:0] LowerAChar = 8'h61;  // 'a'
  localparam logic [7:0] ZeroChar   = 8'h30;  // '0'
  localparam logic [7:0] PlusChar   = 8'h2B;  // '+'
  localparam logic [7:0] SlashChar  = 8'h2F;  // '/'

  // One encoded byte: up to four characters ready to be sent, in order.
  typedef struct packed {
    logic [MaxChars-1:0][7:0] chars;
    logic [1:0]               cnt_m1;  // number of characters minus one
    logic                     last;    // final character closes the message
  } cmd_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'
  function automatic logic [7:0] b64_char(input logic [5:0] idx);
    logic [7:0] c;
    if (idx < 6'd26) begin
      c = UpperAChar + {2'b00, idx};
    end else if (idx < 6'd52) begin
      c = LowerAChar + {2'b00, idx} - 8'd26;
    end else if (idx < 6'd62) begin
      c = ZeroChar + {2'b00, idx} - 8'd52;
    end else if (idx == 6'd62) begin
      c = PlusChar;
    end else begin
      c = SlashChar;
    end
    return c;
  endfunction

endpackage

[src/b64e_in_if.sv]
`timescale 1ns / 1ps
// Input channel: one raw byte per transaction with an end-of-message flag.
interface b64e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/b64e_out_if.sv]
`timescale 1ns / 1ps
// Output channel: one ASCII character per transaction with an end-of-message flag.
interface b64e_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

[src/b64e_front.sv]
`timescale 1ns / 1ps
// Front end: accepts bytes, tracks leftover bits and builds the character list per byte.
module b64e_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  b64e_in_if.sink          in_i,
  input  logic             full_i,
  output logic             push_o,
  output b64e_pkg::cmd_t   cmd_o
);
  import b64e_pkg::*;

  logic [3:0] pend_bits_q, pend_bits_d;
  logic [2:0] pend_cnt_q, pend_cnt_d;
  logic [1:0] mod_q, mod_d;

  logic [11:0] acc;
  logic [3:0]  rem;
  logic [2:0]  n;
  logic [1:0]  mod;
  cmd_t        cmd;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;
  assign cmd_o      = cmd;

  // Split the byte into sextets, then flush and pad on the last byte
  always_comb begin
    acc = {pend_bits_q, in_i.data_byte};
    rem = {1'b0, pend_cnt_q} + 4'd8;
    cmd = '0;
    n   = 3'd0;
    // first sextet always completes
    cmd.chars[0] = b64_char(6'(acc >> (rem - 4'd6)));
    rem = rem - 4'd6;
    n   = 3'd1;
    if (rem >= 4'd6) begin
      cmd.chars[1] = b64_char(6'(acc >> (rem - 4'd6)));
      rem = rem - 4'd6;
      n   = 3'd2;
    end
    mod = mod_q + n[1:0];
    if (in_i.last_byte) begin
      if (rem != 4'd0) begin
        cmd.chars[n[1:0]] = b64_char(6'(acc << (4'd6 - rem)));
        n   = n + 3'd1;
        mod = mod + 2'd1;
      end
      for (int i = 0; i < 3; i++) begin
        if (mod != 2'd0 && n < 3'(MaxChars)) begin
          cmd.chars[n[1:0]] = PadChar;
          n   = n + 3'd1;
          mod = mod + 2'd1;
        end
      end
    end
    cmd.cnt_m1 = 2'(n - 3'd1);
    cmd.last   = in_i.last_byte;
  end

  // Next state: keep leftover bits, clear all after a message ends
  always_comb begin
    pend_bits_d = pend_bits_q;
    pend_cnt_d  = pend_cnt_q;
    mod_d       = mod_q;
    if (push_o) begin
      if (in_i.last_byte) begin
        pend_bits_d = '0;
        pend_cnt_d  = '0;
        mod_d       = '0;
      end else begin
        pend_bits_d = acc[3:0] & ~(4'hF << rem);
        pend_cnt_d  = rem[2:0];
        mod_d       = mod;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
      mod_q       <= '0;
    end else begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
      mod_q       <= mod_d;
    end
  end

endmodule

[src/b64e_fifo.sv]
`timescale 1ns / 1ps
// Two-entry queue of character lists between the front end and the serializer.
module b64e_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64e_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output b64e_pkg::cmd_t cmd_o
);
  import b64e_pkg::*;

  localparam int unsigned Depth = 2;

  cmd_t       mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(Depth));
  assign valid_o = (count_q != 2'd0);
  assign cmd_o   = mem_q[rd_ptr_q];

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = !rd_ptr_q;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[src/b64e_back.sv]
`timescale 1ns / 1ps
// Back end: walks the queued character list and sends one character per cycle while the receiver is ready.
module b64e_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  b64e_pkg::cmd_t cmd_i,
  output logic           pop_o,
  b64e_out_if.source     out_o
);
  import b64e_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_char_q, out_char_d;
  logic       last_char_q, last_char_d;
  logic       load;
  logic       at_end;

  assign load   = valid_i && (!out_valid_q || out_o.ready);
  assign at_end = (idx_q == cmd_i.cnt_m1);
  assign pop_o  = load && at_end;

  assign out_o.valid     = out_valid_q;
  assign out_o.out_char  = out_char_q;
  assign out_o.last_char = last_char_q;

  // Output register load and character index
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    last_char_d = last_char_q;
    if (load) begin
      out_valid_d = 1'b1;
      out_char_d  = cmd_i.chars[idx_q];
      last_char_d = cmd_i.last && at_end;
      idx_d       = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_char_q  <= out_char_d;
    last_char_q <= last_char_d;
  end

endmodule

[src/base64_stream_encoder_core.sv]
`timescale 1ns / 1ps
// A byte's character list passes through the queue and then the output register before its first character appears.
// Throughput: one character per cycle out of the serializer while the receiver is ready;
// a byte makes one to four characters.
// The two-entry queue lets bytes be taken while earlier characters are still being sent.
// Reset: asynchronous, active low; clears leftover bits, queue and output valid.
module base64_stream_encoder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  b64e_in_if.sink    in_i,
  b64e_out_if.source out_o
);
  import b64e_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic cmd_valid;
  cmd_t cmd_in;
  cmd_t cmd_out;

  b64e_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (cmd_in)
  );

  b64e_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (cmd_out)
  );

  b64e_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (cmd_valid),
    .cmd_i   (cmd_out),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the base64 stream encoder: directed rows, random messages.
module testbench;

  localparam int unsigned RandItems   = 186;
  localparam int unsigned CalmItems   = 40;   // last random items run without idling
  localparam int unsigned LongHold    = 64;   // receiver hold-off that fills the core
  localparam int unsigned HoldAfter   = 80;   // characters seen before that hold-off
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned StallLimit  = 2000;

  localparam logic [8*64-1:0] Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } enc_char_t;

  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned n_typed;  // 0: expected characters come from the predictor
    logic [31:0] typed;    // hand-written characters, first one leftmost
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  b64e_in_if  byte_if ();
  b64e_out_if char_if ();

  base64_stream_encoder_core i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (byte_if),
    .out_o (char_if)
  );

  // Predictor state
  logic [3:0]  left_bits;
  int unsigned left_cnt;
  logic [1:0]  chars_mod4;

  enc_char_t   step_chars[$];
  enc_char_t   expected_chars[$];
  stim_row_t   directed_rows[$];

  int unsigned errors;
  int unsigned chars_seen;
  int unsigned idle_cycles;
  bit          calm;
  bit          held_off;

  // Clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic logic [7:0] alpha_char(input logic [5:0] idx);
    return Alphabet[8*(63-idx) +: 8];
  endfunction

  // Characters beyond the fourth of one byte are dropped, as in the core
  function automatic void push_char(input logic [7:0] ch);
    enc_char_t c;
    if (step_chars.size() < 4) begin
      c.ch   = ch;
      c.last = 1'b0;
      step_chars.insert(step_chars.size(), c);
      chars_mod4 = chars_mod4 + 2'd1;
    end
  endfunction

  // Encode one byte into step_chars and advance the leftover-bit state
  function automatic void encode_byte(input logic [7:0] data, input logic is_last);
    logic [11:0] acc;
    int unsigned nbits;
    step_chars.delete();
    acc   = {left_bits, data};
    nbits = left_cnt + 8;
    while (nbits >= 6) begin
      nbits -= 6;
      push_char(alpha_char(6'(acc >> nbits)));
    end
    acc       = acc & ((12'd1 << nbits) - 12'd1);
    left_bits = acc[3:0];
    left_cnt  = nbits;
    if (is_last) begin
      // flush leftover bits, then pad to a multiple of four
      if (nbits > 0) push_char(alpha_char(6'(acc << (6 - nbits))));
      while (chars_mod4 != 2'd0 && step_chars.size() < 4) push_char(b64e_pkg::PadChar);
      if (step_chars.size() > 0) step_chars[step_chars.size()-1].last = 1'b1;
      left_bits  = '0;
      left_cnt   = 0;
      chars_mod4 = '0;
    end
  endfunction

  function automatic void add_row(input logic [7:0] data, input logic last,
                                  input int unsigned n_typed, input logic [31:0] typed);
    stim_row_t row;
    row.data    = data;
    row.last    = last;
    row.n_typed = n_typed;
    row.typed   = typed;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Offer one byte, wait for its transaction, then queue what it should produce
  task automatic issue_byte(input logic [7:0] data, input logic last,
                            input int unsigned n_typed, input logic [31:0] typed);
    enc_char_t e;
    if (!calm && $urandom_range(0, 5) == 0) begin
      byte_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    byte_if.valid     <= 1'b1;
    byte_if.data_byte <= data;
    byte_if.last_byte <= last;
    do @(posedge clk_i); while (!byte_if.ready);
    encode_byte(data, last);
    if (n_typed == 0) begin
      foreach (step_chars[k]) expected_chars.insert(expected_chars.size(), step_chars[k]);
    end else begin
      for (int unsigned k = 0; k < n_typed; k++) begin
        e.ch   = typed[8*(n_typed-1-k) +: 8];
        e.last = last && (k == n_typed - 1);
        expected_chars.insert(expected_chars.size(), e);
      end
    end
  endtask

  // Receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    char_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && !held_off && chars_seen >= HoldAfter) begin
        char_if.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        held_off = 1'b1;
        char_if.ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        char_if.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        char_if.ready <= 1'b1;
      end else begin
        char_if.ready <= 1'b1;
      end
    end
  end

  // Output check against the oldest expected character
  always @(posedge clk_i) begin
    if (rst_ni && char_if.valid && char_if.ready) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time,
                 char_if.out_char, char_if.last_char);
        errors++;
      end else begin
        if (char_if.out_char !== expected_chars[0].ch ||
            char_if.last_char !== expected_chars[0].last) begin
          $display("%0t: expected char %h last %b, got char %h last %b", $time,
                   expected_chars[0].ch, expected_chars[0].last,
                   char_if.out_char, char_if.last_char);
          errors++;
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  // Stall counter for the watchdog
  always @(posedge clk_i) begin
    if ((byte_if.valid && byte_if.ready) || (char_if.valid && char_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Main stimulus
  initial begin
    int unsigned sent;
    int unsigned msg_len;
    logic [7:0]  data;
    rst_ni            = 1'b0;
    byte_if.valid     = 1'b0;
    byte_if.data_byte = '0;
    byte_if.last_byte = 1'b0;
    errors            = 0;
    chars_seen        = 0;
    idle_cycles       = 0;
    calm              = 1'b0;
    held_off          = 1'b0;
    left_bits         = '0;
    left_cnt          = 0;
    chars_mod4        = '0;

    // single-byte messages at the extremes
    add_row(8'h00, 1'b1, 4, "AA==");
    add_row(8'hFF, 1'b1, 4, "/w==");
    // full group, no padding
    add_row(8'h4D, 1'b0, 1, "T");
    add_row(8'h61, 1'b0, 1, "W");
    add_row(8'h6E, 1'b1, 2, "Fu");
    // two bytes: four bits flushed, one pad; then full groups of '/' and of '+'
    add_row(8'h4D, 1'b0, 1, "T");
    add_row(8'h61, 1'b1, 3, "WE=");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b0, 1, "/");
    add_row(8'hFF, 1'b1, 2, "//");
    add_row(8'hFB, 1'b0, 1, "+");
    add_row(8'hEF, 1'b0, 1, "+");
    add_row(8'hBE, 1'b1, 2, "++");
    // longer messages checked by the predictor
    add_row(8'h00, 1'b0, 0, '0);
    add_row(8'h00, 1'b1, 0, '0);
    add_row(8'h12, 1'b0, 0, '0);
    add_row(8'h34, 1'b0, 0, '0);
    add_row(8'h56, 1'b0, 0, '0);
    add_row(8'h78, 1'b1, 0, '0);
    add_row(8'h80, 1'b0, 0, '0);
    add_row(8'h01, 1'b0, 0, '0);
    add_row(8'hAA, 1'b0, 0, '0);
    add_row(8'h55, 1'b0, 0, '0);
    add_row(8'h7F, 1'b1, 0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[r]) begin
      issue_byte(directed_rows[r].data, directed_rows[r].last,
                 directed_rows[r].n_typed, directed_rows[r].typed);
    end

    // Random messages, mostly short, a few long ones
    sent = 0;
    while (sent < RandItems) begin
      msg_len = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0) msg_len = $urandom_range(7, 16);
      for (int unsigned k = 0; k < msg_len; k++) begin
        case ($urandom_range(0, 15))
          0:       data = 8'h00;
          1:       data = 8'hFF;
          default: data = 8'($urandom);
        endcase
        if (sent >= RandItems - CalmItems) calm = 1'b1;
        issue_byte(data, k == msg_len - 1, 0, '0);
        sent++;
      end
    end
    byte_if.valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[base64_stream_encoder_core.f]
src/b64e_pkg.sv
src/b64e_in_if.sv
src/b64e_out_if.sv
src/b64e_front.sv
src/b64e_fifo.sv
src/b64e_back.sv
src/base64_stream_encoder_core.sv
tb/sv/testbench.sv
